FILE: hw/rtl/sipdf_pkg.sv
// Shared types and constants for the SIP stream message deframer.
package sipdf_pkg;

  typedef enum logic [2:0] {
    PH_SEARCH     = 3'd0,
    PH_SKIP_ONE   = 3'd1,
    PH_SEPARATORS = 3'd2,
    PH_DIGITS     = 3'd3,
    PH_TO_CR      = 3'd4,
    PH_BLANK      = 3'd5,
    PH_BODY       = 3'd6,
    PH_HALTED     = 3'd7
  } phase_e;

  typedef struct packed {
    logic msg_end;
    logic error;
  } flags_t;

  localparam logic [3:0] PatternLen = 4'd14;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  function automatic logic [7:0] header_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= ChUpA && b <= ChUpZ) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/sipdf_core.sv
// Framing state machine: header match, length parse, blank line and body count.
module sipdf_core #(
  parameter int LENGTH_BITS = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [7:0]      byte_i,
  output sipdf_pkg::flags_t flags_o
);
  import sipdf_pkg::*;

  localparam int AccBits = LENGTH_BITS + 4;

  phase_e                 phase_q, phase_d;
  logic [3:0]             match_q, match_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [1:0]             prog_q, prog_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic                   error_q, error_d;

  logic [7:0]       lc;
  logic [3:0]       pos;
  logic [3:0]       pos_next;
  logic [AccBits-1:0] acc;
  logic             is_digit;
  logic             overflow;
  logic             is_sep;
  logic             blank_end;
  logic             body_end;

  always_comb begin
    lc       = fold_case(byte_i);
    pos      = (match_q < PatternLen) ? match_q : 4'd0;
    pos_next = (lc == header_char(pos)) ? pos + 4'd1 :
               ((lc == header_char(4'd0)) ? 4'd1 : 4'd0);
    acc      = ({4'b0, len_q} << 3) + ({4'b0, len_q} << 1)
             + {{LENGTH_BITS{1'b0}}, byte_i[3:0]};
    is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
    overflow = |acc[AccBits-1:LENGTH_BITS];
    is_sep   = (phase_q == PH_SEPARATORS) && (byte_i == ChSpace || byte_i == ChColon);
    blank_end = (phase_q == PH_BLANK) && (byte_i == ChLf) && (prog_q == 2'd3);
    body_end  = (phase_q == PH_BODY) && (rem_q <= LENGTH_BITS'(1));
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    len_d   = len_q;
    prog_d  = prog_q;
    rem_d   = rem_q;
    error_d = error_q;
    if (en_i) begin
      case (phase_q)
        PH_SEARCH: begin
          if (pos_next >= PatternLen) begin
            match_d = 4'd0;
            phase_d = PH_SKIP_ONE;
          end else begin
            match_d = pos_next;
          end
        end
        PH_SKIP_ONE: begin
          phase_d = PH_SEPARATORS;
        end
        PH_SEPARATORS, PH_DIGITS: begin
          if (!is_sep) begin
            if (byte_i == ChCr) begin
              prog_d  = 2'd1;
              phase_d = PH_BLANK;
            end else if (byte_i == ChSpace) begin
              phase_d = PH_TO_CR;
            end else if (is_digit && !overflow) begin
              len_d   = acc[LENGTH_BITS-1:0];
              phase_d = PH_DIGITS;
            end else begin
              error_d = 1'b1;
              phase_d = PH_HALTED;
            end
          end
        end
        PH_TO_CR: begin
          if (byte_i == ChCr) begin
            prog_d  = 2'd1;
            phase_d = PH_BLANK;
          end
        end
        PH_BLANK: begin
          if (byte_i == ChCr) begin
            prog_d = (prog_q == 2'd2) ? 2'd3 : 2'd1;
          end else if (byte_i == ChLf && prog_q == 2'd1) begin
            prog_d = 2'd2;
          end else if (blank_end) begin
            if (len_q == '0) begin
              phase_d = PH_SEARCH;
              match_d = 4'd0;
              len_d   = '0;
              prog_d  = 2'd0;
              rem_d   = '0;
            end else begin
              rem_d   = len_q;
              prog_d  = 2'd0;
              phase_d = PH_BODY;
            end
          end else begin
            prog_d = 2'd0;
          end
        end
        PH_BODY: begin
          if (body_end) begin
            phase_d = PH_SEARCH;
            match_d = 4'd0;
            len_d   = '0;
            prog_d  = 2'd0;
            rem_d   = '0;
          end else begin
            rem_d = rem_q - LENGTH_BITS'(1);
          end
        end
        default: begin
          phase_d = PH_HALTED;
        end
      endcase
    end
  end

  // Outputs.
  always_comb begin
    flags_o.msg_end = en_i && ((blank_end && (len_q == '0)) || body_end);
    flags_o.error   = error_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      match_q <= 4'd0;
      len_q   <= '0;
      prog_q  <= 2'd0;
      rem_q   <= '0;
      error_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      match_q <= match_d;
      len_q   <= len_d;
      prog_q  <= prog_d;
      rem_q   <= rem_d;
      error_q <= error_d;
    end
  end

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_q |=> error_q) else $error("error flag cleared");

  a_halt_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALTED) |-> error_q) else $error("halted without error");

  a_end_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_o.msg_end |=> (phase_q == PH_SEARCH && match_q == 4'd0 && rem_q == '0))
    else $error("message end did not restart framing");

  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (rem_q != '0)) else $error("empty body count");

endmodule

FILE: hw/rtl/sip_stream_message_deframer.sv
// Top level: input register, framing core and output register with stall flow.
// An accepted byte passes the input register, the core and the output register.
// Throughput: one byte per cycle unless stalled; framing updates once per byte.
// Stall propagates through the input and output registers only.
// Reset (rst_ni low, asynchronous): both stages empty, framing restarts at the
// header search and the sticky error clears.
module sip_stream_message_deframer #(
  parameter int LENGTH_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] byte_in_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] byte_out_o,
  output logic       message_end_o,
  output logic       frame_error_o
);
  import sipdf_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_end_q;
  logic       out_err_q;
  logic       out_free;
  logic       fire;
  logic       accept;
  flags_t     flags;

  assign out_free = !out_valid_q || !stall_i;
  assign fire     = in_valid_q && out_free;
  assign stall_o  = in_valid_q && !out_free;
  assign accept   = valid_i && !stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  sipdf_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .byte_i  (in_byte_q),
    .flags_o (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= byte_in_i;
    end
    if (fire) begin
      out_byte_q <= in_byte_q;
      out_end_q  <= flags.msg_end;
      out_err_q  <= flags.error;
    end
  end

  assign valid_o       = out_valid_q;
  assign byte_out_o    = out_byte_q;
  assign message_end_o = out_end_q;
  assign frame_error_o = out_err_q;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (in_valid_q && out_valid_q && stall_i)) else $error("spurious stall");

  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q) else $error("result lost");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stall_i) |-> !fire) else $error("held result overwritten");

endmodule

FILE: tb/sip_stream_message_deframer_tb.sv
// Self-checking testbench for the SIP stream message deframer: framed streams, random idling.
module sip_stream_message_deframer_tb;
  import sipdf_pkg::*;

  localparam int LenBits = 24;
  localparam int ItemTarget = 970;
  localparam int CycleLimit = 200000;
  localparam logic [63:0] MaxLen = (64'd1 << LenBits) - 64'd1;
  localparam logic [111:0] HdrText = "content-length";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } deframed_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       valid_i = 1'b0;
  logic       stall_o;
  logic [7:0] byte_in_i = 8'h00;
  logic       valid_o;
  logic       stall_i = 1'b0;
  logic [7:0] byte_out_o;
  logic       message_end_o;
  logic       frame_error_o;

  sip_stream_message_deframer #(
    .LENGTH_BITS(LenBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .byte_in_i    (byte_in_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .byte_out_o   (byte_out_o),
    .message_end_o(message_end_o),
    .frame_error_o(frame_error_o)
  );

  // Stream bytes waiting to be sent; bit 8 holds the sender until the output drains.
  logic [8:0]     pending_bytes[$];
  deframed_word_t deframed_q[$];
  deframed_word_t got_word;

  int  mismatches = 0;
  int  n_taken = 0;
  int  msg_count = 0;
  int  cycle_cnt = 0;
  int  stage1_at = 32'h7fffffff;
  int  stage2_at = 32'h7fffffff;
  int  tx_idle_pct = 18;
  int  rx_idle_pct = 88;
  logic word_taken = 1'b0;

  // Framing state mirrored from the block.
  phase_e             fr_phase = PH_SEARCH;
  logic [3:0]         hdr_pos = 4'd0;
  logic [63:0]        len_acc = 64'd0;
  logic [1:0]         crlf_prog = 2'd0;
  logic [LenBits-1:0] body_left = '0;
  logic               err_sticky = 1'b0;

  function automatic logic [7:0] pattern_char(input int idx);
    return HdrText[8*(13 - idx) +: 8];
  endfunction

  task automatic restart_msg();
    fr_phase = PH_SEARCH;
    hdr_pos = 4'd0;
    len_acc = 64'd0;
    crlf_prog = 2'd0;
    body_left = '0;
  endtask

  task automatic take_value(input logic [7:0] b);
    logic [63:0] v;
    if (b == ChCr) begin
      crlf_prog = 2'd1;
      fr_phase = PH_BLANK;
    end else if (b == ChSpace) begin
      fr_phase = PH_TO_CR;
    end else if (b >= ChZero && b <= ChNine) begin
      v = len_acc * 64'd10 + 64'(b - ChZero);
      if (v > MaxLen) begin
        err_sticky = 1'b1;
        fr_phase = PH_HALTED;
      end else begin
        len_acc = v;
        fr_phase = PH_DIGITS;
      end
    end else begin
      err_sticky = 1'b1;
      fr_phase = PH_HALTED;
    end
  endtask

  task automatic frame_byte(input logic [7:0] b);
    logic [7:0] lc;
    logic [3:0] pos;
    logic       fin;
    fin = 1'b0;
    case (fr_phase)
      PH_SEARCH: begin
        lc = (b >= ChUpA && b <= ChUpZ) ? b + 8'd32 : b;
        pos = (hdr_pos < PatternLen) ? hdr_pos : 4'd0;
        if (lc == pattern_char(pos)) begin
          pos = pos + 4'd1;
        end else begin
          pos = (lc == pattern_char(0)) ? 4'd1 : 4'd0;
        end
        if (pos >= PatternLen) begin
          hdr_pos = 4'd0;
          fr_phase = PH_SKIP_ONE;
        end else begin
          hdr_pos = pos;
        end
      end
      PH_SKIP_ONE: fr_phase = PH_SEPARATORS;
      PH_SEPARATORS: begin
        if (b != ChSpace && b != ChColon) take_value(b);
      end
      PH_DIGITS: take_value(b);
      PH_TO_CR: begin
        if (b == ChCr) begin
          crlf_prog = 2'd1;
          fr_phase = PH_BLANK;
        end
      end
      PH_BLANK: begin
        if (b == ChCr) begin
          crlf_prog = (crlf_prog == 2'd2) ? 2'd3 : 2'd1;
        end else if (b == ChLf && crlf_prog == 2'd1) begin
          crlf_prog = 2'd2;
        end else if (b == ChLf && crlf_prog == 2'd3) begin
          if (len_acc == 64'd0) begin
            fin = 1'b1;
            restart_msg();
          end else begin
            body_left = len_acc[LenBits-1:0];
            crlf_prog = 2'd0;
            fr_phase = PH_BODY;
          end
        end else begin
          crlf_prog = 2'd0;
        end
      end
      PH_BODY: begin
        if (body_left <= 1) begin
          fin = 1'b1;
          restart_msg();
        end else begin
          body_left = body_left - 1'b1;
        end
      end
      default: fr_phase = PH_HALTED;
    endcase
    deframed_q.push_back('{data: b, last: fin, err: err_sticky});
  endtask

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back({1'b0, b});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_crlf();
    push_byte(ChCr);
    push_byte(ChLf);
  endtask

  task automatic push_header_line();
    repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(97, 122)));
    push_text(": ");
    repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(33, 126)));
    if ($urandom_range(0, 9) == 0) push_byte(ChLf);
    if ($urandom_range(0, 9) == 0) push_byte(ChCr);
    push_crlf();
  endtask

  task automatic push_message();
    int         len;
    int         body_n;
    string      digits;
    logic [7:0] c;
    bit         desync;
    bit         pad_zeros;
    desync = (msg_count < 15) && ($urandom_range(0, 99) < 10);
    msg_count++;
    repeat ($urandom_range(0, 1)) push_header_line();
    if ($urandom_range(0, 9) == 0) begin
      push_header_line();
      push_crlf();
      repeat ($urandom_range(0, 8)) push_byte(8'($urandom));
      return;
    end
    case ($urandom_range(0, 6))
      0: push_text("conten");
      1: push_text("Content-");
      default: ;
    endcase
    for (int i = 0; i < 14; i++) begin
      c = pattern_char(i);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
      push_byte(c);
    end
    push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom) : ChColon);
    repeat ($urandom_range(0, 3)) push_byte($urandom_range(0, 1) ? ChSpace : ChColon);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 100) : $urandom_range(0, 16);
    pad_zeros = ($urandom_range(0, 4) == 0);
    if (len == 0 && !pad_zeros && $urandom_range(0, 1) == 1) begin
      digits = "";
    end else begin
      digits = $sformatf("%0d", len);
    end
    if (pad_zeros) repeat ($urandom_range(1, 3)) push_byte(ChZero);
    push_text(digits);
    if (digits.len() != 0 && $urandom_range(0, 3) == 0) begin
      push_byte(ChSpace);
      repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(33, 126)));
    end
    push_crlf();
    repeat ($urandom_range(0, 2)) push_header_line();
    body_n = len;
    if (desync && len > 0 && $urandom_range(0, 1) == 1) begin
      body_n = $urandom_range(0, len - 1);
      push_crlf();
    end else if (!desync) begin
      push_crlf();
    end
    repeat (body_n) push_byte(8'($urandom));
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
    end else if (valid_i && !word_taken) begin
      // hold until accepted
    end else if (pending_bytes.size() != 0 &&
                 !(pending_bytes[0][8] && deframed_q.size() != 0) &&
                 $urandom_range(0, 99) >= tx_idle_pct) begin
      valid_i <= 1'b1;
      byte_in_i <= pending_bytes[0][7:0];
    end else begin
      valid_i <= 1'b0;
      byte_in_i <= 8'($urandom);
    end
  end

  always @(negedge clk_i) begin
    stall_i <= rst_ni && ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    word_taken <= rst_ni && valid_i && !stall_o;
    if (rst_ni && valid_o && !stall_i) begin
      if (deframed_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word byte_out %02h message_end %0b frame_error %0b",
                 $time, byte_out_o, message_end_o, frame_error_o);
      end else begin
        got_word = deframed_q.pop_front();
        if (byte_out_o !== got_word.data || message_end_o !== got_word.last ||
            frame_error_o !== got_word.err) begin
          mismatches++;
          $display("%0t: mismatch byte_out exp %02h got %02h, message_end exp %0b got %0b, %s",
                   $time, got_word.data, byte_out_o, got_word.last, message_end_o,
                   $sformatf("frame_error exp %0b got %0b", got_word.err, frame_error_o));
        end
      end
    end
    if (rst_ni && valid_i && !stall_o) begin
      frame_byte(byte_in_i);
      void'(pending_bytes.pop_front());
      n_taken++;
      if (n_taken >= stage2_at) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (n_taken >= stage1_at) begin
        tx_idle_pct = 88;
        rx_idle_pct = 18;
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL sip_stream_message_deframer");
    $finish;
  end

  initial begin
    int total;
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("CONTENT-LENGTH: ");
    push_crlf();
    push_crlf();
    while (pending_bytes.size() < ItemTarget) push_message();
    // Flush any framing left out of step by truncated messages.
    push_crlf();
    push_crlf();
    repeat (120) push_byte("x");
    push_text("Content-Length: ");
    case ($urandom_range(0, 2))
      0: push_text("12x");
      1: push_text("99999999");
      default: push_text("167772159");
    endcase
    push_crlf();
    push_crlf();
    repeat (30) push_byte(8'($urandom));
    total = pending_bytes.size();
    stage1_at = total / 3;
    stage2_at = 2 * total / 3;
    pending_bytes[total / 4] = pending_bytes[total / 4] | 9'h100;
    pending_bytes[total / 2] = pending_bytes[total / 2] | 9'h100;
    pending_bytes[5 * total / 6] = pending_bytes[5 * total / 6] | 9'h100;
    while (pending_bytes.size() != 0 || deframed_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS sip_stream_message_deframer");
    end else begin
      $display("FAIL sip_stream_message_deframer");
    end
    $finish;
  end

endmodule
